// ----- src/chrb_pkg.sv -----
package chrb_pkg;

	localparam int HISTORY_DEPTH_DEF = 32;
	localparam int LINE_BYTES_DEF    = 64;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_UP   = 2'd1,
		OP_DOWN = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_ACT,
		ST_COPY_H,
		ST_COPY_D,
		ST_LEN,
		ST_LOAD,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic accept;
		logic stage;
		logic clear_stg;
		logic push_end;
		logic push_commit;
		logic up_enter;
		logic up_step;
		logic down_step;
		logic down_exit;
		logic copy_hist;
		logic copy_draft;
		logic load;
		logic send;
		logic emit_refuse;
		logic emit_empty;
	} cmd_t;

	typedef struct packed {
		logic char_ok;
		logic browsing;
		logic dist_zero;
		logic count_zero;
		logic at_oldest;
		logic stg_empty;
		logic is_repeat;
		logic sweep_done;
		logic n_zero;
	} sts_t;

endpackage

// ----- src/chrb_ctrl.sv -----
module chrb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     opcode,
	input  logic           last,
	input  chrb_pkg::sts_t sts,
	output chrb_pkg::cmd_t cmd,
	output logic           busy
);
	import chrb_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				op_q   <= op_t'(opcode);
				last_q <= last;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (op_t'(opcode))
						OP_DOWN: begin
							if (!sts.browsing) begin
								cmd.emit_refuse = 1'b1;
							end else if (sts.dist_zero) begin
								cmd.down_exit = 1'b1;
								state_d = ST_LEN;
							end else begin
								cmd.down_step = 1'b1;
								state_d = ST_LEN;
							end
						end
						OP_PUSH, OP_UP: begin
							if (sts.char_ok) state_d = ST_CHAR;
							else if (last) state_d = ST_ACT;
						end
						default: ;
					endcase
				end
			end
			ST_CHAR: begin
				cmd.stage = 1'b1;
				state_d = last_q ? ST_ACT : ST_IDLE;
			end
			ST_ACT: begin
				cmd.clear_stg = 1'b1;
				state_d = ST_IDLE;
				if (op_q == OP_PUSH) begin
					cmd.push_end = 1'b1;
					if (!sts.stg_empty && !sts.is_repeat) begin
						cmd.push_commit = 1'b1;
						state_d = ST_COPY_H;
					end
				end else if (sts.count_zero || (sts.browsing && sts.at_oldest)) begin
					cmd.emit_refuse = 1'b1;
				end else if (sts.browsing) begin
					cmd.up_step = 1'b1;
					state_d = ST_LEN;
				end else begin
					// first up: staged line becomes the draft
					cmd.up_enter = 1'b1;
					state_d = ST_COPY_D;
				end
			end
			ST_COPY_H: begin
				cmd.copy_hist = 1'b1;
				if (sts.sweep_done) state_d = ST_IDLE;
			end
			ST_COPY_D: begin
				cmd.copy_draft = 1'b1;
				if (sts.sweep_done) state_d = ST_LEN;
			end
			ST_LEN: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (sts.n_zero) begin
					cmd.emit_empty = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.send = 1'b1;
					if (sts.sweep_done) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/chrb_dp.sv -----
module chrb_dp #(
	parameter int HISTORY_DEPTH = chrb_pkg::HISTORY_DEPTH_DEF,
	parameter int LINE_BYTES    = chrb_pkg::LINE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     ch,
	input  logic           has_char,
	input  chrb_pkg::cmd_t cmd,
	output chrb_pkg::sts_t sts,
	output logic           strobe,
	output logic           status,
	output logic [7:0]     out_char,
	output logic           out_valid,
	output logic           out_last,
	output logic [5:0]     line_length
);
	import chrb_pkg::*;

	localparam int LINE_CAP   = LINE_BYTES - 1;
	localparam int COL_W      = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
	localparam int LEN_W      = $clog2(LINE_CAP + 1);
	localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
	localparam int HADDR_W    = SLOT_W + COL_W;
	localparam int HIST_WORDS = HISTORY_DEPTH << COL_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(HISTORY_DEPTH);
	localparam logic [LEN_W-1:0]  CAP_LEN    = LEN_W'(LINE_CAP);

	// rows are 2**COL_W bytes apart
	logic [7:0]       hist_mem  [HIST_WORDS];
	logic [LEN_W-1:0] len_mem   [HISTORY_DEPTH];
	logic [7:0]       stg_mem   [LINE_CAP];
	logic [7:0]       draft_mem [LINE_CAP];

	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] newest_q, browse_slot_q, dist_q, at_q;
	logic [LEN_W-1:0]  newest_len_q, draft_len_q, stg_len_q, idx_q, n_q;
	logic              browsing_q, stg_over_q, stg_diff_q, src_draft_q;
	logic              wr_h_s1, wr_d_s1, send_s1, last_s1;
	logic [COL_W-1:0]  col_s1;
	logic [7:0]        ch_q, hist_rd_q, stg_rd_q, draft_rd_q;
	logic [LEN_W-1:0]  len_rd_q;
	logic              strobe_q, status_q, valid_q, last_q;
	logic [7:0]        char_q;
	logic [LEN_W-1:0]  len_q;

	logic [SLOT_W-1:0]  at_new;
	logic [COL_W-1:0]   idx_col, stg_col;
	logic [HADDR_W-1:0] hist_raddr, hist_waddr;
	logic               sweep_go;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	// when full the slot after the newest is the oldest
	assign at_new     = (count_q == '0) ? '0 : slot_inc(newest_q);
	assign idx_col    = idx_q[COL_W-1:0];
	assign stg_col    = stg_len_q[COL_W-1:0];
	assign hist_raddr = cmd.send ? {browse_slot_q, idx_col} : {newest_q, stg_col};
	assign hist_waddr = {at_q, col_s1};
	assign sweep_go   = (cmd.copy_hist || cmd.copy_draft || cmd.send) && (idx_q != n_q);

	always_comb begin
		sts.char_ok    = has_char && (ch != 8'd0);
		sts.browsing   = browsing_q;
		sts.dist_zero  = (dist_q == '0);
		sts.count_zero = (count_q == '0);
		sts.at_oldest  = (CNT_W'(dist_q) + CNT_W'(1)) >= count_q;
		sts.stg_empty  = (stg_len_q == '0);
		sts.is_repeat  = (count_q != '0) && !stg_over_q && !stg_diff_q
		                 && (stg_len_q == newest_len_q);
		sts.sweep_done = (idx_q == n_q) && !wr_h_s1 && !wr_d_s1 && !send_s1;
		sts.n_zero     = (n_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			newest_q      <= '0;
			newest_len_q  <= '0;
			browsing_q    <= 1'b0;
			dist_q        <= '0;
			browse_slot_q <= '0;
			draft_len_q   <= '0;
			stg_len_q     <= '0;
			stg_over_q    <= 1'b0;
			stg_diff_q    <= 1'b0;
			at_q          <= '0;
			idx_q         <= '0;
			n_q           <= '0;
			src_draft_q   <= 1'b0;
			wr_h_s1       <= 1'b0;
			wr_d_s1       <= 1'b0;
			send_s1       <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			if (cmd.stage) begin
				if (stg_len_q >= CAP_LEN) begin
					stg_over_q <= 1'b1;
				end else begin
					if (count_q != '0 && (stg_len_q >= newest_len_q || hist_rd_q != ch_q))
						stg_diff_q <= 1'b1;
					stg_len_q <= stg_len_q + 1'b1;
				end
			end
			if (cmd.clear_stg) begin
				stg_len_q  <= '0;
				stg_over_q <= 1'b0;
				stg_diff_q <= 1'b0;
			end
			if (cmd.push_end) browsing_q <= 1'b0;
			if (cmd.push_commit) begin
				newest_q     <= at_new;
				at_q         <= at_new;
				newest_len_q <= stg_len_q;
				if (count_q != FULL_COUNT) count_q <= count_q + 1'b1;
				idx_q <= '0;
				n_q   <= stg_len_q;
			end
			if (cmd.up_enter) begin
				browsing_q    <= 1'b1;
				dist_q        <= '0;
				browse_slot_q <= newest_q;
				draft_len_q   <= stg_len_q;
				src_draft_q   <= 1'b0;
				idx_q         <= '0;
				n_q           <= stg_len_q;
			end
			if (cmd.up_step) begin
				dist_q        <= dist_q + 1'b1;
				browse_slot_q <= slot_dec(browse_slot_q);
				src_draft_q   <= 1'b0;
			end
			if (cmd.down_step) begin
				dist_q        <= dist_q - 1'b1;
				browse_slot_q <= slot_inc(browse_slot_q);
				src_draft_q   <= 1'b0;
			end
			if (cmd.down_exit) begin
				browsing_q  <= 1'b0;
				src_draft_q <= 1'b1;
			end
			if (cmd.load) begin
				n_q   <= src_draft_q ? draft_len_q : len_rd_q;
				idx_q <= '0;
			end
			if (sweep_go) idx_q <= idx_q + 1'b1;
			wr_h_s1  <= sweep_go && cmd.copy_hist;
			wr_d_s1  <= sweep_go && cmd.copy_draft;
			send_s1  <= sweep_go && cmd.send;
			strobe_q <= send_s1 || cmd.emit_refuse || cmd.emit_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) ch_q <= ch;
		col_s1  <= idx_col;
		last_s1 <= (idx_q + 1'b1) == n_q;
		if (send_s1) begin
			status_q <= 1'b0;
			char_q   <= src_draft_q ? draft_rd_q : hist_rd_q;
			valid_q  <= 1'b1;
			last_q   <= last_s1;
			len_q    <= n_q;
		end else if (cmd.emit_refuse || cmd.emit_empty) begin
			status_q <= cmd.emit_refuse;
			char_q   <= 8'd0;
			valid_q  <= 1'b0;
			last_q   <= 1'b1;
			len_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_h_s1) hist_mem[hist_waddr] <= stg_rd_q;
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_commit) len_mem[at_new] <= stg_len_q;
		len_rd_q <= len_mem[browse_slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.stage && stg_len_q < CAP_LEN) stg_mem[stg_col] <= ch_q;
		stg_rd_q <= stg_mem[idx_col];
	end

	always_ff @(posedge clk) begin
		if (wr_d_s1) draft_mem[col_s1] <= stg_rd_q;
		draft_rd_q <= draft_mem[idx_col];
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign out_char    = char_q;
	assign out_valid   = valid_q;
	assign out_last    = last_q;
	assign line_length = 6'(len_q);

endmodule

// ----- src/command_history_ring_browser.sv -----
// A char beat before the last is staged in ST_CHAR. A push on the last beat passes ST_ACT,
// then, if stored, copies the line in ST_COPY_H; byte memories have one read and one write port.
// A down beat goes through ST_LEN, ST_LOAD and ST_SEND; an up beat first through ST_CHAR (with
// a char) and ST_ACT, plus the ST_COPY_D draft copy on entering browse; then one beat a cycle.
// A refused down beat is answered in the next cycle, a refused up beat after ST_ACT. Results
// cannot be held off. Async active-low reset empties the ring and leaves browse mode; bytes are not cleared.
module command_history_ring_browser #(
	parameter int HISTORY_DEPTH = chrb_pkg::HISTORY_DEPTH_DEF,
	parameter int LINE_BYTES    = chrb_pkg::LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [7:0] ch,
	input  logic       has_char,
	input  logic       last,
	output logic       strobe,
	output logic       status,
	output logic [7:0] out_char,
	output logic       out_valid,
	output logic       out_last,
	output logic [5:0] line_length
);
	import chrb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	chrb_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.LINE_BYTES    (LINE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ch          (ch),
		.has_char    (has_char),
		.cmd         (cmd),
		.sts         (sts),
		.strobe      (strobe),
		.status      (status),
		.out_char    (out_char),
		.out_valid   (out_valid),
		.out_last    (out_last),
		.line_length (line_length)
	);

endmodule

// ----- src/chrb_checker.sv -----
module chrb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       strobe,
	input logic       status,
	input logic [7:0] out_char,
	input logic       out_valid,
	input logic       out_last,
	input logic [5:0] line_length
);

	// a beat without a character always closes the answer
	a_empty_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !out_valid |-> out_last && out_char == 8'd0)
		else $error("empty or refused beat not final");

	a_refuse_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> !out_valid && line_length == 6'd0)
		else $error("refusal carries data");

	a_refuse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> !busy)
		else $error("refusal while still busy");

	// a line streams out with no gaps
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && out_valid && !out_last |=> strobe && out_valid && !status
		&& $stable(line_length))
		else $error("line stream broken");

endmodule

bind command_history_ring_browser chrb_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.strobe      (strobe),
	.status      (status),
	.out_char    (out_char),
	.out_valid   (out_valid),
	.out_last    (out_last),
	.line_length (line_length)
);
